// ----- src/line_average_deinterlacer_assert.svh -----
// assertion macros for the line average deinterlacer
`ifndef LINE_AVERAGE_DEINTERLACER_ASSERT_SVH
`define LINE_AVERAGE_DEINTERLACER_ASSERT_SVH
`ifndef SYNTHESIS
`define LAD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LAD_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define LAD_ASSERT(lbl, clk, rst, prop, msg)
`define LAD_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ----- src/lad_pkg.sv -----
// shared types and constants of the line average deinterlacer
package lad_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_HEIGHT  = 2048;
   localparam int QUEUE_DEPTH = 4;
   localparam int POS_W       = 11;
   localparam int RSP_DATA_W  = 48;

   localparam logic [1:0] REG_ENABLE    = 2'd0;
   localparam logic [1:0] REG_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_WIDTH     = 2'd2;
   localparam logic [1:0] REG_HEIGHT    = 2'd3;

   localparam logic        RESET_ENABLE    = 1'b0;
   localparam logic [7:0]  RESET_THRESHOLD = 8'd5;
   localparam logic [11:0] RESET_WIDTH     = 12'd640;
   localparam logic [11:0] RESET_HEIGHT    = 12'd480;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pix_type;

   typedef struct packed {
      logic        deinterlace_enable;
      logic [7:0]  gray_threshold;
      logic [11:0] frame_width;
      logic [11:0] frame_height;
   } cfg_type;

   typedef struct packed {
      logic             repair;
      pix_type          fix;
      pix_type          pix;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] fix_row;
      logic [POS_W-1:0] col;
   } rec_type;

endpackage

// ----- src/lad_ram.sv -----
// generic single write port ram with registered read
module lad_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/lad_front.sv -----
// front end: position tracking, line stores and repair decision
`include "line_average_deinterlacer_assert.svh"
module lad_front #(
   parameter int MAX_WIDTH  = lad_pkg::MAX_WIDTH,
   parameter int MAX_HEIGHT = lad_pkg::MAX_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  lad_pkg::pix_type pix,
   input  logic             frame_start,
   input  lad_pkg::cfg_type cfg,
   output logic             push,
   output lad_pkg::rec_type rec
);

   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int HA  = $clog2(MAX_HEIGHT);
   localparam int XW0 = (AW + 1 > 12) ? AW + 1 : 12;
   localparam int XW  = (HA + 1 > XW0) ? HA + 1 : XW0;
   localparam int PW  = lad_pkg::POS_W;

   function automatic logic [7:0] gray_of(input lad_pkg::pix_type p);
      logic [12:0] s;
      s = 13'(p.red) * 13'd11 + 13'({p.green, 4'b0000}) + 13'(p.blue) * 13'd5;
      return s[12:5];
   endfunction

   function automatic lad_pkg::pix_type avg_of(input lad_pkg::pix_type a,
                                               input lad_pkg::pix_type b);
      logic [8:0]       sr;
      logic [8:0]       sg;
      logic [8:0]       sb;
      lad_pkg::pix_type o;
      sr = 9'(a.red) + 9'(b.red);
      sg = 9'(a.green) + 9'(b.green);
      sb = 9'(a.blue) + 9'(b.blue);
      o.red   = sr[8:1];
      o.green = sg[8:1];
      o.blue  = sb[8:1];
      return o;
   endfunction

   logic [AW-1:0] col_ff, col_in;
   logic [HA-1:0] row_ff, row_in;
   logic [XW-1:0] w_x, h_x, wc, hc, c0, r0, c1x, r1x, r2x, cnx, rnx;
   logic [AW-1:0] cur_col;
   logic [HA-1:0] cur_row;
   logic          even, repair_in;

   logic             s1_valid_ff;
   logic             s1_repair_ff;
   lad_pkg::pix_type s1_pix_ff;
   logic [HA-1:0]    s1_row_ff;
   logic [AW-1:0]    s1_col_ff;

   logic [23:0]       above_raw, mid_raw;
   lad_pkg::pix_type  above, mid, fix;
   logic signed [10:0] diff, thr2;

   always_comb begin
      w_x = XW'(cfg.frame_width);
      h_x = XW'(cfg.frame_height);
      wc  = (w_x == '0) ? XW'(1) : ((w_x > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : w_x);
      hc  = (h_x == '0) ? XW'(1) : ((h_x > XW'(MAX_HEIGHT)) ? XW'(MAX_HEIGHT) : h_x);
      c0  = frame_start ? '0 : XW'(col_ff);
      r0  = frame_start ? '0 : XW'(row_ff);
      if (c0 >= wc) begin
         c1x = '0;
         r1x = r0 + XW'(1);
      end else begin
         c1x = c0;
         r1x = r0;
      end
      r2x     = (r1x >= hc) ? '0 : r1x;
      cur_col = AW'(c1x);
      cur_row = HA'(r2x);
      cnx     = c1x + XW'(1);
      rnx     = r2x + XW'(1);
      if (cnx >= wc) begin
         col_in = '0;
         row_in = (rnx >= hc) ? '0 : HA'(rnx);
      end else begin
         col_in = AW'(cnx);
         row_in = cur_row;
      end
      even      = ~cur_row[0];
      repair_in = cfg.deinterlace_enable & even & (r2x >= XW'(2));
   end

   lad_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_even_store (
      .clock   (clock),
      .wr_en   (accept & even),
      .wr_addr (cur_col),
      .wr_data (pix),
      .rd_addr (cur_col),
      .rd_data (above_raw)
   );

   lad_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_odd_store (
      .clock   (clock),
      .wr_en   (accept & ~even),
      .wr_addr (cur_col),
      .wr_data (pix),
      .rd_addr (cur_col),
      .rd_data (mid_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
      if (accept) begin
         s1_repair_ff <= repair_in;
         s1_pix_ff    <= pix;
         s1_row_ff    <= cur_row;
         s1_col_ff    <= cur_col;
      end
   end

   always_comb begin
      above = above_raw;
      mid   = mid_raw;
      diff  = $signed({3'b000, gray_of(above)}) + $signed({3'b000, gray_of(s1_pix_ff)})
            - $signed({2'b00, gray_of(mid), 1'b0});
      thr2  = $signed({2'b00, cfg.gray_threshold, 1'b0});
      fix   = (diff > thr2) ? avg_of(above, s1_pix_ff) : mid;
      rec.repair  = s1_repair_ff;
      rec.fix     = fix;
      rec.pix     = s1_pix_ff;
      rec.row     = PW'(s1_row_ff);
      rec.fix_row = PW'(s1_row_ff - HA'(1));
      rec.col     = PW'(s1_col_ff);
   end

   assign push = s1_valid_ff;

   `LAD_ASSERT(a_repair_row, clock, reset,
      (s1_valid_ff && s1_repair_ff) |-> (!s1_row_ff[0] && s1_row_ff >= HA'(2)),
      "repair issued on a row that has no odd line above")

endmodule

// ----- src/lad_queue.sv -----
// short queue between front and back end
`include "line_average_deinterlacer_assert.svh"
module lad_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lad_pkg::rec_type push_rec,
   input  logic             pop,
   output logic             not_empty,
   output lad_pkg::rec_type head_rec,
   output logic [$clog2(lad_pkg::QUEUE_DEPTH+1)-1:0] level
);

   localparam int DEPTH = lad_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   lad_pkg::rec_type mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_rec  = mem_ff[rd_ptr_ff];
   assign level     = count_ff;

   `LAD_ASSERT(a_no_overflow, clock, reset,
      (count_ff == CW'(DEPTH)) |-> (!push || pop),
      "queue written while full")
   `LAD_ASSERT(a_no_underflow, clock, reset,
      pop |-> (count_ff != '0),
      "queue read while empty")

endmodule

// ----- src/lad_back.sv -----
// back end: splits queue entries into result beats behind an output register
`include "line_average_deinterlacer_assert.svh"
module lad_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  lad_pkg::rec_type                 q_rec,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lad_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int DW = lad_pkg::RSP_DATA_W;

   logic          rsp_valid_ff;
   logic [DW-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          phase_ff, phase_in;
   logic          load, beat_is_repair;

   always_comb begin
      load           = q_valid & (~rsp_valid_ff | rsp_tready);
      beat_is_repair = q_rec.repair & ~phase_ff;
      pop            = load & ~beat_is_repair;
      phase_in       = load ? beat_is_repair : phase_ff;
      if (beat_is_repair) begin
         rsp_data_in = DW'({q_rec.col, q_rec.fix_row, q_rec.fix});
         rsp_last_in = 1'b0;
      end else begin
         rsp_data_in = DW'({q_rec.col, q_rec.row, q_rec.pix});
         rsp_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `LAD_ASSERT(a_repair_pending, clock, reset,
      (rsp_valid_ff && !rsp_last_ff) |-> phase_ff,
      "repair beat shown without its pixel beat pending")
   `LAD_ASSERT(a_phase_entry, clock, reset,
      phase_ff |-> q_valid,
      "entry left the queue before its pixel beat")
   `LAD_ASSERT_NEXT(a_repair_load, clock, reset,
      load && beat_is_repair,
      rsp_valid_ff && !rsp_last_ff && phase_ff,
      "repair beat not loaded into output register")

endmodule

// ----- src/line_average_deinterlacer.sv -----
// line average deinterlacer: pixel stream in, repaired and passed pixels out
//
// req channel takes one rgb pixel per beat in raster order, tuser marks the
// first pixel of a frame. rsp channel returns result beats with row and column
// so a frame buffer can write them in place. a pixel on an odd line, on line
// zero, or any pixel while repair is off gives one beat (tlast high). with
// repair on, a pixel on an even line two or higher gives two beats: first the
// repaired odd pixel above it (tlast low), then the pixel itself.
// the first beat of a pixel passes the line store read, the queue write and the
// output register before it shows on rsp.
// throughput: one pixel per cycle in while req_tready is high, one beat per
// cycle out while rsp_tready is high; on repaired lines the output side sets
// the pace at two beats per pixel, the four entry queue absorbs short bursts.
// the csr channel is always ready and writes one register per beat; write it
// only while no pixel is in flight.
// reset: registers return to their defaults (repair off, threshold 5, 640x480),
// position counters go to zero, line store contents are undefined until
// written. a stalled rsp fills the queue and then drops req_tready.
module line_average_deinterlacer #(
   parameter int MAX_WIDTH  = lad_pkg::MAX_WIDTH,
   parameter int MAX_HEIGHT = lad_pkg::MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,  // red_in, green_in, blue_in
   input  logic                           req_tuser,  // frame_start
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lad_pkg::RSP_DATA_W-1:0] rsp_tdata,  // red_out, green_out, blue_out, row, column
   output logic                           rsp_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [11:0]                    csr_data
);

   localparam int CW = $clog2(lad_pkg::QUEUE_DEPTH + 1);

   lad_pkg::cfg_type cfg_ff, cfg_in;
   logic             accept, push, pop, q_valid;
   lad_pkg::rec_type push_rec, head_rec;
   logic [CW-1:0]    level;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lad_pkg::REG_ENABLE:    cfg_in.deinterlace_enable = csr_data[0];
            lad_pkg::REG_THRESHOLD: cfg_in.gray_threshold     = csr_data[7:0];
            lad_pkg::REG_WIDTH:     cfg_in.frame_width        = csr_data;
            lad_pkg::REG_HEIGHT:    cfg_in.frame_height       = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deinterlace_enable <= lad_pkg::RESET_ENABLE;
         cfg_ff.gray_threshold     <= lad_pkg::RESET_THRESHOLD;
         cfg_ff.frame_width        <= lad_pkg::RESET_WIDTH;
         cfg_ff.frame_height       <= lad_pkg::RESET_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (level + CW'(push)) < CW'(lad_pkg::QUEUE_DEPTH);
   assign accept     = req_tvalid & req_tready;

   lad_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pix         (req_tdata),
      .frame_start (req_tuser),
      .cfg         (cfg_ff),
      .push        (push),
      .rec         (push_rec)
   );

   lad_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .pop       (pop),
      .not_empty (q_valid),
      .head_rec  (head_rec),
      .level     (level)
   );

   lad_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_rec      (head_rec),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
